// File: hw/rtl/lir_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lir_pkg: shared constants for the linear interpolation resampler
// Field widths, register indexes and limits used by the core, the
// interpolation unit and the port checker.
// ----------------------------------------------------------------------------
package lir_pkg;

    // payload widths
    localparam int SAMPLE_W  = 16;
    localparam int CHAN_W    = 3;
    localparam int STEP_W    = 37;
    localparam int COUNT_W   = 4;
    localparam int CFG_IDX_W = 4;
    localparam int SKIP_W    = 5;
    localparam int RES_CNT_W = 7;

    // default build parameters
    localparam int MAX_CHANNELS_DEF = 8;
    localparam int FRAC_BITS_DEF    = 32;

    // limits
    localparam int MAX_RESULTS = 64;
    localparam int SKIP_MAX    = 31;

    // register reset values
    localparam logic [STEP_W-1:0]  STEP_RESET  = 37'h01_0000_0000;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RATIO    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 4'd1;

endpackage : lir_pkg
`default_nettype wire

// File: hw/rtl/lir_interp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lir_interp: shared interpolation unit
// Two-step unit: capture the bracketing samples and the phase, then form
// the exact product (cur - prev) * phase. The result, prev plus the product
// scaled down with truncation toward zero, is read from the registers.
// ----------------------------------------------------------------------------
module lir_interp #(
    parameter int FRAC_BITS = lir_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                load_en,
    input  wire logic                                mult_en,
    input  wire logic signed [lir_pkg::SAMPLE_W-1:0] prev_sample,
    input  wire logic signed [lir_pkg::SAMPLE_W-1:0] cur_sample,
    input  wire logic        [FRAC_BITS-1:0]         frac,
    output logic signed      [lir_pkg::SAMPLE_W-1:0] result
);
    import lir_pkg::*;

    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
    localparam int TOT_W  = PROD_W + 1;

    logic signed [SAMPLE_W-1:0] base_reg, base_next;
    logic signed [DIFF_W-1:0]   diff_reg, diff_next;
    logic        [FRAC_BITS-1:0] frac_reg, frac_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;

    logic signed [FRAC_BITS:0]  frac_s;
    logic signed [TOT_W-1:0]    base_sh;
    logic signed [TOT_W-1:0]    total;
    logic        [SAMPLE_W-1:0] floor_q;
    logic                       round_up;

    // operand capture and exact product
    always_comb
    begin
        base_next = base_reg;
        diff_next = diff_reg;
        frac_next = frac_reg;
        prod_next = prod_reg;
        frac_s    = $signed({1'b0, frac_reg});
        if (load_en)
        begin
            base_next = prev_sample;
            diff_next = DIFF_W'(cur_sample) - DIFF_W'(prev_sample);
            frac_next = frac;
        end
        if (mult_en)
        begin
            prod_next = PROD_W'(diff_reg) * PROD_W'(frac_s);
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        diff_reg <= diff_next;
        frac_reg <= frac_next;
        prod_reg <= prod_next;
    end

    // sum, then shift down with truncation toward zero
    always_comb
    begin
        base_sh  = TOT_W'(base_reg) <<< FRAC_BITS;
        total    = base_sh + TOT_W'(prod_reg);
        floor_q  = total[FRAC_BITS +: SAMPLE_W];
        round_up = total[TOT_W-1] && (|total[FRAC_BITS-1:0]);
        result   = $signed(floor_q + SAMPLE_W'(round_up));
    end

endmodule : lir_interp
`default_nettype wire

// File: hw/rtl/linear_interp_resampler_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// linear_interp_resampler_core: streaming linear interpolation resampler
// Interleaved samples in, interpolated samples out, with a configurable
// input/output rate ratio and channel count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / sample_in) takes one interleaved
//   sample per transaction. Channel order follows the frame position; the
//   last channel of a frame completes it. The first frame after reset only
//   primes the history.
//   Output channel (out_valid / out_stall / sample_out, chan_index,
//   last_of_run) gives one interpolated sample per transaction. last_of_run
//   marks the final result caused by one input sample.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) is always
//   ready; write it only while the block is idle. Index 0 is the step ratio
//   (Q.FRAC_BITS), index 1 the channel count.
// Sequencing:
//   A frame that emits N results sends all of them one at a time through
//   the single shared multiplier (load, multiply, sum). N is at most 64.
//   in_stall is high while a run is in progress. A stalled receiver holds
//   the output register and halts the run until the result is taken.
// Reset: history and phase clear, step ratio 1.0, one channel, and the
//   first frame is skipped.
// ----------------------------------------------------------------------------
module linear_interp_resampler_core #(
    parameter int MAX_CHANNELS = lir_pkg::MAX_CHANNELS_DEF,
    parameter int FRAC_BITS    = lir_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // input channel
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [lir_pkg::SAMPLE_W-1:0]  sample_in,
    // output channel
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed      [lir_pkg::SAMPLE_W-1:0]  sample_out,
    output logic             [lir_pkg::CHAN_W-1:0]    chan_index,
    output logic                                      last_of_run,
    // configuration channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic        [lir_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [lir_pkg::STEP_W-1:0]    cfg_data
);
    import lir_pkg::*;

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int ACC_W = STEP_W + 1;
    localparam int ADV_W = ACC_W - FRAC_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MULT,
        ST_SUM
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    // resampler state
    logic signed [SAMPLE_W-1:0] prev_reg [MAX_CHANNELS];
    logic signed [SAMPLE_W-1:0] prev_next [MAX_CHANNELS];
    logic signed [SAMPLE_W-1:0] cur_reg [MAX_CHANNELS];
    logic signed [SAMPLE_W-1:0] cur_next [MAX_CHANNELS];
    logic [FRAC_BITS-1:0]       phase_reg, phase_next;
    logic [SKIP_W-1:0]          skip_reg, skip_next;
    logic [CH_W-1:0]            chan_pos_reg, chan_pos_next;

    // sequencer counters
    logic [CH_W-1:0]            k_reg, k_next;
    logic [RES_CNT_W-1:0]       n_reg, n_next;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_out_reg, sample_out_next;
    logic [CHAN_W-1:0]          chan_reg, chan_next;
    logic                       last_reg, last_next;

    logic [COUNT_W-1:0]         nch;
    logic [ACC_W-1:0]           acc;
    logic [ADV_W-1:0]           adv;
    logic [ADV_W-1:0]           adv_m1;
    logic                       adv_nz;
    logic [SKIP_W-1:0]          skip_val;
    logic                       round_end;
    logic                       last_k;
    logic                       frame_done;
    logic                       out_free;
    logic                       load_en;
    logic                       mult_en;
    logic signed [SAMPLE_W-1:0] interp_result;

    // active channel count, clamped to the supported range
    always_comb
    begin
        if (count_reg == '0)
        begin
            nch = COUNT_W'(1);
        end
        else if (count_reg > COUNT_W'(MAX_CHANNELS))
        begin
            nch = COUNT_W'(MAX_CHANNELS);
        end
        else
        begin
            nch = count_reg;
        end
    end

    // phase advance and run bookkeeping
    always_comb
    begin
        acc       = ACC_W'(step_reg) + ACC_W'(phase_reg);
        adv       = acc[ACC_W-1:FRAC_BITS];
        adv_nz    = |adv;
        adv_m1    = adv - ADV_W'(1);
        skip_val  = (adv_m1 > ADV_W'(SKIP_MAX)) ? SKIP_W'(SKIP_MAX) : adv_m1[SKIP_W-1:0];
        round_end = adv_nz
                    || ((8'(n_reg) + 8'(nch) + 8'(nch)) > 8'(MAX_RESULTS));
        last_k     = (COUNT_W'(k_reg) + COUNT_W'(1)) == nch;
        frame_done = !((5'(chan_pos_reg) + 5'd1) < 5'(nch));
        out_free   = !out_valid_reg || !out_stall;
    end

    // shared interpolation unit
    lir_interp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_interp (
        .clk         (clk),
        .load_en     (load_en),
        .mult_en     (mult_en),
        .prev_sample (prev_reg[k_reg]),
        .cur_sample  (cur_reg[k_reg]),
        .frac        (phase_reg),
        .result      (interp_result)
    );

    // sequencer and next-state logic
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        count_next      = count_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        phase_next      = phase_reg;
        skip_next       = skip_reg;
        chan_pos_next   = chan_pos_reg;
        k_next          = k_reg;
        n_next          = n_reg;
        out_valid_next  = out_valid_reg;
        sample_out_next = sample_out_reg;
        chan_next       = chan_reg;
        last_next       = last_reg;
        load_en         = 1'b0;
        mult_en         = 1'b0;

        // config write
        if (cfg_valid)
        begin
            if (cfg_index == REG_STEP_RATIO)
            begin
                step_next = cfg_data;
            end
            else if (cfg_index == REG_CHANNEL_COUNT)
            begin
                count_next = cfg_data[COUNT_W-1:0];
            end
        end

        // output transaction completes
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    prev_next[chan_pos_reg] = cur_reg[chan_pos_reg];
                    cur_next[chan_pos_reg]  = sample_in;
                    if (!frame_done)
                    begin
                        chan_pos_next = chan_pos_reg + CH_W'(1);
                    end
                    else
                    begin
                        chan_pos_next = '0;
                        if (skip_reg != '0)
                        begin
                            skip_next = skip_reg - SKIP_W'(1);
                        end
                        else
                        begin
                            k_next     = '0;
                            n_next     = '0;
                            state_next = ST_LOAD;
                        end
                    end
                end
            end
            ST_LOAD:
            begin
                load_en    = 1'b1;
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                mult_en    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    sample_out_next = interp_result;
                    chan_next       = CHAN_W'(k_reg);
                    last_next       = last_k && round_end;
                    if (last_k)
                    begin
                        // end of one frame of results: advance the phase
                        phase_next = acc[FRAC_BITS-1:0];
                        n_next     = n_reg + RES_CNT_W'(nch);
                        if (adv_nz)
                        begin
                            skip_next = skip_val;
                        end
                        if (round_end)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            k_next     = '0;
                            state_next = ST_LOAD;
                        end
                    end
                    else
                    begin
                        k_next     = k_reg + CH_W'(1);
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= STEP_RESET;
            count_reg      <= COUNT_RESET;
            prev_reg       <= '{default: '0};
            cur_reg        <= '{default: '0};
            phase_reg      <= '0;
            skip_reg       <= SKIP_W'(1);
            chan_pos_reg   <= '0;
            k_reg          <= '0;
            n_reg          <= '0;
            out_valid_reg  <= 1'b0;
            sample_out_reg <= '0;
            chan_reg       <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            count_reg      <= count_next;
            prev_reg       <= prev_next;
            cur_reg        <= cur_next;
            phase_reg      <= phase_next;
            skip_reg       <= skip_next;
            chan_pos_reg   <= chan_pos_next;
            k_reg          <= k_next;
            n_reg          <= n_next;
            out_valid_reg  <= out_valid_next;
            sample_out_reg <= sample_out_next;
            chan_reg       <= chan_next;
            last_reg       <= last_next;
        end
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign sample_out  = sample_out_reg;
    assign chan_index  = chan_reg;
    assign last_of_run = last_reg;
    assign cfg_ready   = 1'b1;

endmodule : linear_interp_resampler_core
`default_nettype wire

// File: hw/rtl/lir_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lir_checker: port-level checks for the resampler core
// Watches the channels of the top level and flags ordering and
// handshake slips.
// ----------------------------------------------------------------------------
module lir_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 in_valid,
    input wire logic                                 in_stall,
    input wire logic                                 out_valid,
    input wire logic                                 out_stall,
    input wire logic signed [lir_pkg::SAMPLE_W-1:0]  sample_out,
    input wire logic        [lir_pkg::CHAN_W-1:0]    chan_index,
    input wire logic                                 last_of_run
);
    import lir_pkg::*;

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output valid dropped under stall");

    // a stalled result does not change
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(sample_out) && $stable(chan_index)
                                   && $stable(last_of_run))
        else $error("output payload changed under stall");

    // while a run is still open the input side is held off
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> in_stall)
        else $error("input taken in the middle of a run");

    // no result can appear the cycle after an input transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result produced faster than the interpolation unit allows");

endmodule : lir_checker

bind linear_interp_resampler_core lir_checker u_lir_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample_out  (sample_out),
    .chan_index  (chan_index),
    .last_of_run (last_of_run)
);
`default_nettype wire
